// File: rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication check
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/sra_pkg.sv
package sra_pkg;

  localparam int ATLAS_SIZE_DEF = 256;
  localparam int RECT_BITS      = 9;
  localparam int COORD_BITS     = 8;
  localparam int IN_DATA_BITS   = 24;
  localparam int OUT_DATA_BITS  = 24;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_DRAIN,
    ST_DECIDE,
    ST_WRITE,
    ST_EMIT
  } state_t;

  // issue-stage control for one column of a scan
  typedef struct packed {
    logic valid;
    logic second;
    logic restart;
    logic cand;
  } scan_ctrl_t;

endpackage

// File: rtl/core/skyline_rect_allocator_core.sv
// a request of width 1..ATLAS_SIZE-1 runs a forward and a backward pass over the single read
// port of the column memory, a drain step, a decide step and, if granted, w column writes before
// its word is emitted; a refused one skips the writes; width 0 or ATLAS_SIZE and up goes straight
// to the decide step; one request at a time, and emit waits while out_tready holds the last word
// reset: synchronous active-low rst_n, then a clearing pass
// zeroes every column while in_tready stays low
module skyline_rect_allocator_core #(
  parameter int AtlasSize = sra_pkg::ATLAS_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sra_pkg::IN_DATA_BITS-1:0]  in_tdata,   // rect_width[8:0], rect_height[17:9]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sra_pkg::OUT_DATA_BITS-1:0] out_tdata   // granted[0], place_x[8:1], place_y[16:9]
);

  localparam int AddrW = $clog2(AtlasSize);
  localparam int FillW = $clog2(AtlasSize + 1);
  localparam int CmpW  = ((sra_pkg::RECT_BITS > AddrW) ? sra_pkg::RECT_BITS : AddrW) + 1;
  localparam int SumW  = ((sra_pkg::RECT_BITS > FillW) ? sra_pkg::RECT_BITS : FillW) + 1;
  localparam int RB    = sra_pkg::RECT_BITS;
  localparam int CB    = sra_pkg::COORD_BITS;

  sra_pkg::state_t     state_r, state_nxt;
  sra_pkg::scan_ctrl_t ctrl;

  // request and sequencer registers
  logic [RB-1:0]    w_r, h_r;
  logic [RB-1:0]    rem_r, rem_nxt;
  logic [AddrW-1:0] cnt_r, cnt_nxt;
  logic [AddrW-1:0] pos_r, pos_nxt;
  logic [AddrW-1:0] wm1;
  logic             cnt_last;
  logic             load_in;
  logic             scan_start;
  logic             decide;
  logic             out_load;

  // incoming request fields
  logic [RB-1:0] in_w, in_h;
  logic          in_skip;

  // column memory
  logic [FillW-1:0] fill_mem [AtlasSize];
  logic [FillW-1:0] fill_rd_r;
  logic             fill_we;
  logic [FillW-1:0] fill_wdata;
  logic [AddrW-1:0] pref_raddr;

  // scan results
  logic             found_w;
  logic [FillW-1:0] best_w;
  logic [AddrW-1:0] best_x_w;

  // decision
  logic            w_zero, w_big, grant;
  logic [SumW-1:0] top_sum;
  logic            res_granted_r;
  logic [CB-1:0]   res_x_r, res_y_r;
  logic [FillW-1:0] newh_r;

  // output word
  logic                              out_tvalid_r;
  logic [sra_pkg::OUT_DATA_BITS-1:0] out_tdata_r;

  assign in_w     = in_tdata[RB-1:0];
  assign in_h     = in_tdata[2*RB-1:RB];
  assign in_skip  = (in_w == '0) || (CmpW'(in_w) >= CmpW'(AtlasSize));
  assign wm1      = AddrW'(w_r) - AddrW'(1);
  assign cnt_last = (cnt_r == AddrW'(AtlasSize - 1));
  assign in_tready = (state_r == sra_pkg::ST_IDLE);

  // fit check on the best span found
  assign w_zero  = (w_r == '0);
  assign w_big   = (CmpW'(w_r) >= CmpW'(AtlasSize));
  assign top_sum = SumW'(best_w) + SumW'(h_r);
  always_comb begin
    if (w_zero) begin
      grant = (SumW'(h_r) <= SumW'(AtlasSize));
    end else begin
      grant = !w_big && found_w && (top_sum <= SumW'(AtlasSize));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sra_pkg::ST_CLEAR:  if (cnt_last) state_nxt = sra_pkg::ST_IDLE;
      sra_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_skip ? sra_pkg::ST_DECIDE : sra_pkg::ST_PASS1;
        end
      end
      sra_pkg::ST_PASS1:  if (cnt_last) state_nxt = sra_pkg::ST_PASS2;
      sra_pkg::ST_PASS2:  if (cnt_r == '0) state_nxt = sra_pkg::ST_DRAIN;
      sra_pkg::ST_DRAIN:  state_nxt = sra_pkg::ST_DECIDE;
      sra_pkg::ST_DECIDE: begin
        state_nxt = (grant && !w_zero) ? sra_pkg::ST_WRITE : sra_pkg::ST_EMIT;
      end
      sra_pkg::ST_WRITE:  if (rem_r == RB'(1)) state_nxt = sra_pkg::ST_EMIT;
      sra_pkg::ST_EMIT:   if (out_load) state_nxt = sra_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    fill_we    = 1'b0;
    fill_wdata = '0;
    pref_raddr = AddrW'(cnt_r + wm1);
    ctrl       = '0;
    scan_start = 1'b0;
    load_in    = 1'b0;
    decide     = 1'b0;
    out_load   = 1'b0;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    unique case (state_r)
      sra_pkg::ST_CLEAR: begin
        fill_we = 1'b1;
        cnt_nxt = cnt_last ? '0 : cnt_r + AddrW'(1);
      end
      sra_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          load_in    = 1'b1;
          scan_start = 1'b1;
          cnt_nxt    = '0;
          pos_nxt    = '0;
        end
      end
      sra_pkg::ST_PASS1: begin
        // forward: prefix max inside blocks of w columns
        ctrl.valid   = 1'b1;
        ctrl.restart = (pos_r == '0);
        if (!cnt_last) begin
          cnt_nxt = cnt_r + AddrW'(1);
          pos_nxt = (pos_r == wm1) ? '0 : pos_r + AddrW'(1);
        end
      end
      sra_pkg::ST_PASS2: begin
        // backward: suffix max joined with prefix max at the window end
        ctrl.valid   = 1'b1;
        ctrl.second  = 1'b1;
        ctrl.restart = cnt_last || (pos_r == wm1);
        ctrl.cand    = (CmpW'(cnt_r) + CmpW'(w_r)) < CmpW'(AtlasSize);
        pos_nxt      = (pos_r == '0) ? wm1 : pos_r - AddrW'(1);
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - AddrW'(1);
        end
      end
      sra_pkg::ST_DRAIN: begin
        // last scan column still in the compare stage
      end
      sra_pkg::ST_DECIDE: begin
        decide  = 1'b1;
        cnt_nxt = best_x_w;
        rem_nxt = w_r;
      end
      sra_pkg::ST_WRITE: begin
        fill_we    = 1'b1;
        fill_wdata = newh_r;
        cnt_nxt    = cnt_r + AddrW'(1);
        rem_nxt    = rem_r - RB'(1);
      end
      sra_pkg::ST_EMIT: begin
        out_load = !out_tvalid_r || out_tready;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sra_pkg::ST_CLEAR;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    if (load_in) begin
      w_r <= in_w;
      h_r <= in_h;
    end
    if (decide) begin
      res_granted_r <= grant;
      res_x_r       <= (grant && !w_zero) ? CB'(best_x_w) : '0;
      res_y_r       <= (grant && !w_zero) ? CB'(best_w) : '0;
      newh_r        <= FillW'(top_sum);
    end
    if (out_load) begin
      out_tdata_r <= {7'd0, res_y_r, res_x_r, res_granted_r};
    end
  end

  // column fill heights, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[cnt_r] <= fill_wdata;
    end
    fill_rd_r <= fill_mem[cnt_r];
  end

  // shared window max and best-position compare
  sra_scan_unit #(
    .AtlasSize (AtlasSize)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (scan_start),
    .ctrl_i       (ctrl),
    .idx_i        (cnt_r),
    .pref_raddr_i (pref_raddr),
    .fill_rd_i    (fill_rd_r),
    .found_o      (found_w),
    .best_o       (best_w),
    .best_x_o     (best_x_w)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `include "assert_macros.svh"

  // a fresh result word only ever comes out of the emit step
  `ASSERT_IMPL(a_out_from_emit, $rose(out_tvalid_r), $past(state_r == sra_pkg::ST_EMIT), "result word without emit")
  // a found span is always below the atlas top
  `ASSERT_IMPL(a_best_in_range, found_w, best_w < FillW'(AtlasSize), "best span height out of range")
  // raised columns never pass the atlas top
  `ASSERT_IMPL(a_write_in_range, state_r == sra_pkg::ST_WRITE, newh_r <= FillW'(AtlasSize), "column raised past atlas")
  // column writes stay inside the atlas
  `ASSERT_IMPL(a_write_addr, state_r == sra_pkg::ST_WRITE, CmpW'(cnt_r) < CmpW'(AtlasSize), "column write out of range")

endmodule

// File: rtl/core/sra_scan_unit.sv
module sra_scan_unit #(
  parameter int AtlasSize = sra_pkg::ATLAS_SIZE_DEF,
  localparam int AddrW = $clog2(AtlasSize),
  localparam int FillW = $clog2(AtlasSize + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  sra_pkg::scan_ctrl_t  ctrl_i,
  input  logic [AddrW-1:0]     idx_i,
  input  logic [AddrW-1:0]     pref_raddr_i,
  input  logic [FillW-1:0]     fill_rd_i,
  output logic                 found_o,
  output logic [FillW-1:0]     best_o,
  output logic [AddrW-1:0]     best_x_o
);

  sra_pkg::scan_ctrl_t ctrl_r;
  logic [AddrW-1:0]    idx_r;
  logic [FillW-1:0]    pref_mem [AtlasSize];
  logic [FillW-1:0]    pref_rd_r;
  logic [FillW-1:0]    run_r;
  logic [FillW-1:0]    run_sel;
  logic [FillW-1:0]    span;
  logic [FillW-1:0]    best_r;
  logic [AddrW-1:0]    best_x_r;
  logic                found_r;
  logic                take;

  // running max restarts at each block edge
  always_comb begin
    run_sel = (ctrl_r.restart || (fill_rd_i > run_r)) ? fill_rd_i : run_r;
    span    = (pref_rd_r > run_sel) ? pref_rd_r : run_sel;
    take    = ctrl_r.valid && ctrl_r.second && ctrl_r.cand &&
              (span < FillW'(AtlasSize)) && (span <= best_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_i;
    if (ctrl_r.valid) begin
      run_r <= run_sel;
    end
  end

  // block prefix maxima from the forward pass
  always_ff @(posedge clk) begin
    if (ctrl_r.valid && !ctrl_r.second) begin
      pref_mem[idx_r] <= run_sel;
    end
    pref_rd_r <= pref_mem[pref_raddr_i];
  end

  // backward scan, so ties go to the later visit (lower x)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (start_i) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      best_r <= FillW'(AtlasSize);
    end else if (take) begin
      best_r   <= span;
      best_x_r <= idx_r;
    end
  end

  assign found_o  = found_r;
  assign best_o   = best_r;
  assign best_x_o = best_x_r;

endmodule
